[design/lvn_pkg.sv]
// Shared types, constants and codes for the lattice value noise block.
// Used by every module in this folder; depends on nothing.
package lvn_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int FRAC_W        = 10;
   localparam int WGT_W         = FRAC_W + 1;
   localparam int FADE_K        = 1536;
   localparam int FADE_SH       = 19;
   localparam int BLEND_SH      = 15;
   localparam int CSR_IDX_W     = 2;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [FRAC_W-1:0] frac_type;
   typedef logic [WGT_W-1:0]  wgt_type;

   // Item kinds.
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_EVAL = 1'b1;

   // Noise modes; any code with the upper bit set is sharp.
   localparam logic [1:0] MODE_SMOOTH = 2'd0;
   localparam logic [1:0] MODE_WRAP   = 2'd1;
   localparam logic [1:0] MODE_SHARP  = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_Z = 2'd2;

   localparam idx_type IDX_ALL = idx_type'(TABLE_ENTRIES - 1);
   localparam wgt_type WGT_ONE = wgt_type'(1 << FRAC_W);

endpackage

[design/lattice_value_noise_3d.sv]
// Lattice value noise, 3D. Throughput: one beat per cycle while the result is
// not stalled; the three nested lookups run on replicated table copies (1, 2
// and 4 copies, two read ports each). Reset clears the pipeline valid bits, the
// output valid bit and the wrap masks (to all ones); the output value register
// is not reset, and the table contents are undefined until loaded.
module lattice_value_noise_3d
   import lvn_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_action,
   input  idx_type              req_entry_index,
   input  idx_type              req_entry_value,
   input  logic signed [31:0]   req_coord_x,
   input  logic signed [31:0]   req_coord_y,
   input  logic signed [31:0]   req_coord_z,
   input  logic [1:0]           req_noise_mode,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output idx_type              rsp_noise_value,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  idx_type              csr_wr_data
);

   logic    en;
   idx_type mask_x_ff, mask_y_ff, mask_z_ff;

   // Pipeline control.
   logic ld1_ff, ld2_ff, ld3_ff;
   logic ev1_ff, ev2_ff, ev3_ff, ev4_ff, ev5_ff, ev6_ff;
   logic rsp_valid_ff, rsp_valid_in;
   idx_type rsp_value_ff;

   // Stage payloads.
   idx_type  eidx1_ff, eidx2_ff, eidx3_ff, eval1_ff, eval2_ff, eval3_ff;
   idx_type  cell_ff [3];
   idx_type  xi2_ff, xi3_ff, yi2_ff, mx1_ff, mx2_ff, mx3_ff, my1_ff, my2_ff, mz1_ff;
   frac_type f1_ff [3], f2_ff [3];
   logic     sharp1_ff, sharp2_ff;
   logic [2*FRAC_W-1:0] ff2_ff [3];
   wgt_type  k2_ff [3];
   wgt_type  w3_ff [3], w4_ff [3], w3_in [3];
   logic [2*FRAC_W+WGT_W-1:0] fade [3];

   idx_type  a_rd [2];
   idx_type  b_rd [4];
   idx_type  c_rd [8];
   idx_type  noise;
   logic     is_eval;

   // The pipeline moves unless a finished result would overwrite a waiting one.
   assign en        = !rsp_valid_ff || rsp_ready || !ev6_ff;
   assign req_ready = en;
   assign is_eval   = (req_action == ACT_EVAL);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_x_ff <= IDX_ALL;
         mask_y_ff <= IDX_ALL;
         mask_z_ff <= IDX_ALL;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MASK_X: mask_x_ff <= csr_wr_data;
            CSR_MASK_Y: mask_y_ff <= csr_wr_data;
            CSR_MASK_Z: mask_z_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         ld1_ff <= 1'b0; ld2_ff <= 1'b0; ld3_ff <= 1'b0;
         ev1_ff <= 1'b0; ev2_ff <= 1'b0; ev3_ff <= 1'b0;
         ev4_ff <= 1'b0; ev5_ff <= 1'b0; ev6_ff <= 1'b0;
      end else if (en) begin
         ld1_ff <= req_valid && !is_eval;
         ev1_ff <= req_valid && is_eval;
         ld2_ff <= ld1_ff; ld3_ff <= ld2_ff;
         ev2_ff <= ev1_ff; ev3_ff <= ev2_ff; ev4_ff <= ev3_ff;
         ev5_ff <= ev4_ff; ev6_ff <= ev5_ff;
      end
   end

   // Stage 1: split coordinates, pick masks.
   always_ff @(posedge clock) begin
      if (en) begin
         eidx1_ff   <= req_entry_index;
         eval1_ff   <= req_entry_value;
         cell_ff[0] <= idx_type'(req_coord_x[FRAC_W +: IDX_W]);
         cell_ff[1] <= idx_type'(req_coord_y[FRAC_W +: IDX_W]);
         cell_ff[2] <= idx_type'(req_coord_z[FRAC_W +: IDX_W]);
         f1_ff[0]   <= req_coord_x[FRAC_W-1:0];
         f1_ff[1]   <= req_coord_y[FRAC_W-1:0];
         f1_ff[2]   <= req_coord_z[FRAC_W-1:0];
         sharp1_ff  <= req_noise_mode[1];
         mx1_ff     <= (req_noise_mode == MODE_WRAP) ? mask_x_ff : IDX_ALL;
         my1_ff     <= (req_noise_mode == MODE_WRAP) ? mask_y_ff : IDX_ALL;
         mz1_ff     <= (req_noise_mode == MODE_WRAP) ? mask_z_ff : IDX_ALL;
      end
   end

   // Stage 2: fade square and complement; the z lookup is in flight.
   always_ff @(posedge clock) begin
      if (en) begin
         eidx2_ff  <= eidx1_ff;
         eval2_ff  <= eval1_ff;
         xi2_ff    <= cell_ff[0];
         yi2_ff    <= cell_ff[1];
         mx2_ff    <= mx1_ff;
         my2_ff    <= my1_ff;
         sharp2_ff <= sharp1_ff;
         for (int i = 0; i < 3; i++) begin
            f2_ff[i]  <= f1_ff[i];
            ff2_ff[i] <= {{FRAC_W{1'b0}}, f1_ff[i]} * {{FRAC_W{1'b0}}, f1_ff[i]};
            k2_ff[i]  <= wgt_type'(FADE_K) - wgt_type'(f1_ff[i]);
         end
      end
   end

   // Stage 3: final weights.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fade[i]  = {{WGT_W{1'b0}}, ff2_ff[i]} * {{2*FRAC_W{1'b0}}, k2_ff[i]};
         w3_in[i] = sharp2_ff ? wgt_type'(f2_ff[i]) : wgt_type'(fade[i] >> FADE_SH);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         eidx3_ff <= eidx2_ff;
         eval3_ff <= eval2_ff;
         xi3_ff   <= xi2_ff;
         mx3_ff   <= mx2_ff;
         w3_ff    <= w3_in;
         w4_ff    <= w3_ff;
      end
   end

   // First lookup level: the two z corners.
   lvn_ram u_ram_z (
      .clock     (clock),
      .en        (en),
      .wr_en     (en && ld1_ff),
      .wr_addr   (eidx1_ff),
      .wr_data   (eval1_ff),
      .rd_addr_a (cell_ff[2] & mz1_ff),
      .rd_addr_b (idx_type'(cell_ff[2] + 1'b1) & mz1_ff),
      .rd_data_a (a_rd[0]),
      .rd_data_b (a_rd[1])
   );

   // Second level: y corners, one table copy per z corner.
   for (genvar k = 0; k < 2; k++) begin : g_lvl_y
      lvn_ram u_ram_y (
         .clock     (clock),
         .en        (en),
         .wr_en     (en && ld2_ff),
         .wr_addr   (eidx2_ff),
         .wr_data   (eval2_ff),
         .rd_addr_a (idx_type'(a_rd[k] + yi2_ff) & my2_ff),
         .rd_addr_b (idx_type'(a_rd[k] + yi2_ff + 1'b1) & my2_ff),
         .rd_data_a (b_rd[2*k]),
         .rd_data_b (b_rd[2*k+1])
      );
   end

   // Third level: x corners, one table copy per (z, y) pair.
   for (genvar j = 0; j < 4; j++) begin : g_lvl_x
      lvn_ram u_ram_x (
         .clock     (clock),
         .en        (en),
         .wr_en     (en && ld3_ff),
         .wr_addr   (eidx3_ff),
         .wr_data   (eval3_ff),
         .rd_addr_a (idx_type'(b_rd[j] + xi3_ff) & mx3_ff),
         .rd_addr_b (idx_type'(b_rd[j] + xi3_ff + 1'b1) & mx3_ff),
         .rd_data_a (c_rd[2*j]),
         .rd_data_b (c_rd[2*j+1])
      );
   end

   // Stages 5 to 6 and the last blend.
   lvn_blend u_blend (
      .clock  (clock),
      .en     (en),
      .corner (c_rd),
      .wx     (w4_ff[0]),
      .wy     (w4_ff[1]),
      .wz     (w4_ff[2]),
      .noise  (noise)
   );

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (en && ev6_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && ev6_ff) begin
         rsp_value_ff <= noise;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;

endmodule

[design/lvn_ram.sv]
// Permutation table copy: one write port, two registered read ports.
// Depends on lvn_pkg.
module lvn_ram
   import lvn_pkg::*;
(
   input  logic    clock,
   input  logic    en,
   input  logic    wr_en,
   input  idx_type wr_addr,
   input  idx_type wr_data,
   input  idx_type rd_addr_a,
   input  idx_type rd_addr_b,
   output idx_type rd_data_a,
   output idx_type rd_data_b
);

   idx_type mem [TABLE_ENTRIES];
   idx_type rd_a_ff;
   idx_type rd_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read ports hold their data while the pipeline is stalled.
   always_ff @(posedge clock) begin
      if (en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[design/lvn_blend.sv]
// Trilinear blend of the eight corner values; the x and y blends are registered, the z blend is combinational.
// Depends on lvn_pkg.
module lvn_blend
   import lvn_pkg::*;
(
   input  logic    clock,
   input  logic    en,
   input  idx_type corner [8],
   input  wgt_type wx,
   input  wgt_type wy,
   input  wgt_type wz,
   output idx_type noise
);

   logic [IDX_W+WGT_W-1:0]          a_in  [4];
   logic [IDX_W+WGT_W-1:0]          a_ff  [4];
   wgt_type                         wy_ff, wz5_ff, wz6_ff;
   logic [IDX_W+2*WGT_W-BLEND_SH-1:0] s_in [2];
   logic [IDX_W+2*WGT_W-BLEND_SH-1:0] s_ff [2];
   logic [IDX_W+3*WGT_W-BLEND_SH-1:0] sum_z;
   wgt_type                         vz;

   // Blend along x: corner index is {z, y, x}.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         a_in[k] = (IDX_W+WGT_W)'(corner[2*k] * (WGT_ONE - wx))
                 + (IDX_W+WGT_W)'(corner[2*k+1] * wx);
      end
   end

   // Blend along y with the first truncation.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         s_in[k] = (IDX_W+2*WGT_W-BLEND_SH)'(
                     ((IDX_W+2*WGT_W)'(a_ff[2*k] * (WGT_ONE - wy_ff))
                    + (IDX_W+2*WGT_W)'(a_ff[2*k+1] * wy_ff)) >> BLEND_SH);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff   <= a_in;
         wy_ff  <= wy;
         wz5_ff <= wz;
         s_ff   <= s_in;
         wz6_ff <= wz5_ff;
      end
   end

   // Blend along z; the result is taken into the output register upstream.
   assign vz    = WGT_ONE - wz6_ff;
   assign sum_z = (IDX_W+3*WGT_W-BLEND_SH)'(s_ff[0] * vz)
                + (IDX_W+3*WGT_W-BLEND_SH)'(s_ff[1] * wz6_ff);
   assign noise = idx_type'(sum_z >> BLEND_SH);

endmodule

[sim/lvn_checker.sv]
// Checker for the lattice value noise block: it watches the request, response
// and register ports, predicts each noise value and compares it in order.
// Depends on lvn_pkg for types, codes and constants.
module lvn_checker
   import lvn_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_action,
   input  idx_type              req_entry_index,
   input  idx_type              req_entry_value,
   input  logic signed [31:0]   req_coord_x,
   input  logic signed [31:0]   req_coord_y,
   input  logic signed [31:0]   req_coord_z,
   input  logic [1:0]           req_noise_mode,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  idx_type              rsp_noise_value,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  idx_type              csr_wr_data,
   output int                   fail_count,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   idx_type perm_table [TABLE_ENTRIES];
   idx_type mask_x, mask_y, mask_z;
   idx_type noise_queue [$];

   // Fade curve for smooth modes, raw fraction for sharp ones.
   function automatic bit [31:0] fade_weight(bit [31:0] f, bit sharp);
      if (sharp) return f;
      return (f * f * (FADE_K - f)) >> FADE_SH;
   endfunction

   // Three nested lookups give the value at one lattice corner.
   function automatic bit [31:0] corner_value(bit [31:0] xi, bit [31:0] yi, bit [31:0] zi,
                                              idx_type mx, idx_type my, idx_type mz);
      bit [31:0] a, b;
      a = perm_table[idx_type'(zi) & mz];
      b = perm_table[idx_type'(a + yi) & my];
      return perm_table[idx_type'(b + xi) & mx];
   endfunction

   // Trilinear blend of the eight corners of the cell holding (x, y, z).
   function automatic idx_type noise_at(bit [31:0] x, bit [31:0] y, bit [31:0] z,
                                        logic [1:0] mode);
      bit [31:0] wx, wy, wz, vx, vy, vz, xi, yi, zi, zk, a0, a1;
      bit [31:0] s [2];
      idx_type   mx, my, mz;
      bit        sharp;
      sharp = mode[1];
      if (mode == MODE_WRAP) begin
         mx = mask_x; my = mask_y; mz = mask_z;
      end else begin
         mx = IDX_ALL; my = IDX_ALL; mz = IDX_ALL;
      end
      wx = fade_weight(x & IDX_ALL, sharp);
      wy = fade_weight(y & IDX_ALL, sharp);
      wz = fade_weight(z & IDX_ALL, sharp);
      vx = WGT_ONE - wx;
      vy = WGT_ONE - wy;
      vz = WGT_ONE - wz;
      xi = (x >> FRAC_W) & IDX_ALL;
      yi = (y >> FRAC_W) & IDX_ALL;
      zi = (z >> FRAC_W) & IDX_ALL;
      for (int k = 0; k < 2; k++) begin
         zk = zi + k;
         a0 = corner_value(xi, yi, zk, mx, my, mz) * vx
            + corner_value(xi + 1, yi, zk, mx, my, mz) * wx;
         a1 = corner_value(xi, yi + 1, zk, mx, my, mz) * vx
            + corner_value(xi + 1, yi + 1, zk, mx, my, mz) * wx;
         s[k] = (a0 * vy + a1 * wy) >> BLEND_SH;
      end
      return idx_type'((s[0] * vz + s[1] * wz) >> BLEND_SH);
   endfunction

   // Track registers and table loads, predict on evaluate beats, compare results.
   always @(posedge clock) begin
      idx_type want;
      if (reset) begin
         mask_x <= IDX_ALL;
         mask_y <= IDX_ALL;
         mask_z <= IDX_ALL;
         noise_queue.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MASK_X: mask_x <= csr_wr_data;
               CSR_MASK_Y: mask_y <= csr_wr_data;
               CSR_MASK_Z: mask_z <= csr_wr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_action == ACT_LOAD)
               perm_table[req_entry_index] = req_entry_value;
            else
               noise_queue.push_back(noise_at(req_coord_x, req_coord_y, req_coord_z,
                                              req_noise_mode));
         end
         if (rsp_valid && rsp_ready) begin
            if (noise_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: result beat %0d with nothing expected", $realtime,
                           rsp_noise_value);
               fail_count <= fail_count + 1;
            end else begin
               want = noise_queue.pop_front();
               if (want !== rsp_noise_value) begin
                  if (fail_count < 10)
                     $display("%0t: noise_value expected %0d got %0d", $realtime,
                              want, rsp_noise_value);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= noise_queue.size();
      end
   end

endmodule

[sim/lattice_value_noise_3d_tb.sv]
// Testbench top for lattice_value_noise_3d: drives loads, evaluates and mask
// writes with random gaps and stalls; lvn_checker does the checking.
// Depends on lvn_pkg, the design and sim/lvn_checker.sv.
module lattice_value_noise_3d_tb;
   import lvn_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [1:0]           MODE_SPARE = MODE_SHARP | MODE_WRAP;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_action = ACT_LOAD;
   idx_type              req_entry_index = '0;
   idx_type              req_entry_value = '0;
   logic signed [31:0]   req_coord_x = '0;
   logic signed [31:0]   req_coord_y = '0;
   logic signed [31:0]   req_coord_z = '0;
   logic [1:0]           req_noise_mode = MODE_SMOOTH;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   idx_type              rsp_noise_value;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MASK_X;
   idx_type              csr_wr_data = '0;
   int                   fail_count;
   int                   pending;
   bit                   burst = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lattice_value_noise_3d u_top (.*);

   lvn_checker u_checker (.*);

   // Hard stop in case the block hangs.
   initial begin
      #5ms;
      $display("lattice_value_noise_3d_tb: errors");
      $finish;
   end

   // Result side: a random stall before each beat, none during bursts.
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = burst ? 0 : $urandom_range(0, 19);
         if (stall != 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // One request beat after a random gap; held until accepted.
   task automatic send_beat(logic act, idx_type idx, idx_type val,
                            logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [1:0] mode);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 19);
      repeat (gap) @(negedge clock);
      req_valid       = 1'b1;
      req_action      = act;
      req_entry_index = idx;
      req_entry_value = val;
      req_coord_x     = x;
      req_coord_y     = y;
      req_coord_z     = z;
      req_noise_mode  = mode;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic evaluate(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [1:0] mode);
      send_beat(ACT_EVAL, idx_type'($urandom), idx_type'($urandom), x, y, z, mode);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, idx_type data);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Let every result drain, then allow the pipeline to empty out behind loads.
   task automatic settle();
      while (pending != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   initial begin
      idx_type masks [5][3];
      int      phase_items;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Fill the whole table first so no evaluate reads an unwritten slot.
      for (int i = 0; i < TABLE_ENTRIES; i++)
         send_beat(ACT_LOAD, idx_type'(i),
                   (i == 0) ? IDX_ALL : (i == 1) ? idx_type'(0) : idx_type'($urandom),
                   $urandom, $urandom, $urandom, 2'($urandom));

      // Directed evaluates under the reset masks.
      evaluate(0, 0, 0, MODE_SMOOTH);
      evaluate('1, '1, '1, MODE_SMOOTH);
      evaluate(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, MODE_SMOOTH);
      evaluate(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, MODE_SHARP);
      evaluate(32'h3ff, 32'h3ff, 32'h3ff, MODE_SMOOTH);
      evaluate(32'h3ff, 32'h3ff, 32'h3ff, MODE_SHARP);
      // Cell index 1023 wraps to 0 for its upper neighbor.
      evaluate(32'h000f_fc00 | 300, 32'h000f_fe00, 32'h000f_fc01, MODE_SMOOTH);
      evaluate(32'h000f_fc00 | 300, 32'h000f_fe00, 32'h000f_fc01, MODE_WRAP);
      evaluate($urandom, $urandom, $urandom, MODE_WRAP);
      // The spare mode code behaves as sharp without masks.
      evaluate($urandom, $urandom, $urandom, MODE_SPARE);
      evaluate(32'h0000_0200, 32'hffff_fe00, 32'h0001_0155, MODE_SPARE);
      // A load with busy coordinate fields still yields no result.
      send_beat(ACT_LOAD, IDX_ALL, IDX_ALL, '1, '1, '1, MODE_WRAP);
      evaluate('1, '1, '1, MODE_WRAP);
      evaluate(32'h0000_07ff, 32'hfffff_c00, 32'h0000_0400, MODE_SMOOTH);

      // Mask settings per phase, extremes among them.
      masks[0] = '{IDX_ALL, IDX_ALL, IDX_ALL};
      masks[1] = '{idx_type'(0), idx_type'(0), idx_type'(0)};
      masks[2] = '{idx_type'($urandom), idx_type'($urandom), idx_type'($urandom)};
      masks[3] = '{IDX_ALL, idx_type'(0), idx_type'(511)};
      masks[4] = '{idx_type'(15), idx_type'($urandom), IDX_ALL};
      for (int p = 0; p < 5; p++) begin
         settle();
         csr_write(CSR_MASK_X, masks[p][0]);
         csr_write(CSR_MASK_Y, masks[p][1]);
         csr_write(CSR_MASK_Z, masks[p][2]);
         if (p == 2) csr_write(CSR_UNUSED, idx_type'($urandom));
         phase_items = 160;
         for (int n = 0; n < phase_items; n++) begin
            // Every fourth stretch of forty beats runs without gaps or stalls.
            burst = ((n / 40) % 4) == (p % 4);
            if ($urandom_range(0, 4) == 0)
               send_beat(ACT_LOAD, idx_type'($urandom), idx_type'($urandom),
                         $urandom, $urandom, $urandom, 2'($urandom));
            else if ($urandom_range(0, 3) == 0)
               evaluate($urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                        $urandom_range(0, 8191) - 4096, 2'($urandom));
            else
               evaluate($urandom, $urandom, $urandom, 2'($urandom));
         end
         burst = 1'b0;
      end

      settle();
      if (fail_count == 0)
         $display("lattice_value_noise_3d_tb: clean");
      else
         $display("lattice_value_noise_3d_tb: errors");
      $finish;
   end

endmodule
